### rtl/core/thpc_pkg.sv
// Shared types and constants for the temperature, pressure and humidity compensation block.
`timescale 1ns / 1ps

package thpc_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_CALIB  = 3'd0,
      CSR_PRESS_LOW   = 3'd1,
      CSR_PRESS_HIGH  = 3'd2,
      CSR_PRESS_LAST  = 3'd3,
      CSR_HUM_CALIB   = 3'd4
   } csr_index_type;

   localparam int CSR_DATA_W = 64;

   // Calibration words, laid out exactly as the registers pack them.
   typedef struct packed {
      logic signed [15:0] t3;
      logic signed [15:0] t2;
      logic        [15:0] t1;
   } temp_coef_type;

   typedef struct packed {
      logic signed [15:0] p4;
      logic signed [15:0] p3;
      logic signed [15:0] p2;
      logic        [15:0] p1;
   } press_low_type;

   typedef struct packed {
      logic signed [15:0] p8;
      logic signed [15:0] p7;
      logic signed [15:0] p6;
      logic signed [15:0] p5;
   } press_high_type;

   typedef struct packed {
      logic signed [7:0]  h6;
      logic signed [11:0] h5;
      logic signed [11:0] h4;
      logic        [7:0]  h3;
      logic signed [15:0] h2;
      logic        [7:0]  h1;
   } hum_coef_type;

   // Results that ride alongside the pressure division.
   typedef struct packed {
      logic signed [31:0] temp;
      logic        [16:0] hum;
      logic               pvalid;
   } side_type;

   // Divider: one quotient bit per stage, plus operand and sign stages.
   localparam int DIV_W   = 64;
   localparam int DIV_LAT = DIV_W + 2;

   // Humidity pipeline depth and clamp value (100 percent in Q22.10 scaled by 2^12).
   localparam int          HUM_LAT = 8;
   localparam logic [31:0] HUM_MAX = 32'd419430400;

endpackage

### rtl/core/thpc_if.sv
// Channel interfaces for sample requests, results and configuration writes.
`timescale 1ns / 1ps

interface thpc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   logic [15:0] raw_humidity;

   modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
   modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface thpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic        [31:0] pressure_q24_8;
   logic               pressure_valid;
   logic        [16:0] humidity_q22_10;

   modport source (output valid, temperature_centi, pressure_q24_8, pressure_valid,
                   humidity_q22_10, input ready);
   modport sink   (input valid, temperature_centi, pressure_q24_8, pressure_valid,
                   humidity_q22_10, output ready);
endinterface

interface thpc_csr_if import thpc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/thpc_hum.sv
// Eight-stage humidity compensation pipeline driven by the fine temperature.
`timescale 1ns / 1ps

module thpc_hum import thpc_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [31:0] fine,
   input  logic        [15:0] adc_h,
   input  hum_coef_type       coef,
   output logic        [16:0] hum
);

   logic        [7:0]  h1;
   logic signed [15:0] h2;
   logic        [7:0]  h3;
   logic signed [11:0] h4;
   logic signed [11:0] h5;
   logic signed [7:0]  h6;

   assign h1 = coef.h1;
   assign h2 = coef.h2;
   assign h3 = coef.h3;
   assign h4 = coef.h4;
   assign h5 = coef.h5;
   assign h6 = coef.h6;

   // Stage 1: offset temperature and its three coefficient products.
   logic signed [31:0] hv_in;
   logic signed [43:0] m5_in;
   logic signed [39:0] m6_in;
   logic signed [40:0] m3_in;
   logic        [31:0] base_in;
   logic        [31:0] base_ff, m5_ff, m6_ff, m3_ff;

   assign hv_in   = fine - 32'sd76800;
   assign m5_in   = h5 * hv_in;
   assign m6_in   = hv_in * h6;
   assign m3_in   = hv_in * $signed({1'b0, h3});
   assign base_in = {2'b00, adc_h, 14'b0} - {h4, 20'b0} + 32'd16384;

   // Stage 2: raw humidity term and the two temperature factors.
   logic [31:0] diff2;
   logic [31:0] u2_in, wa_in, wb_in;
   logic [31:0] u2_ff, wa_ff, wb_ff;

   assign diff2 = base_ff - m5_ff;
   assign u2_in = {{15{diff2[31]}}, diff2[31:15]};
   assign wa_in = {{10{m6_ff[31]}}, m6_ff[31:10]};
   assign wb_in = {{11{m3_ff[31]}}, m3_ff[31:11]} + 32'd32768;

   // Stage 3: product of the temperature factors.
   logic signed [63:0] wp_in;
   logic        [31:0] wp_ff, u3_ff;

   assign wp_in = $signed(wa_ff) * $signed(wb_ff);

   // Stage 4: offset and scale by H2.
   logic        [31:0] w2;
   logic signed [47:0] wh_in;
   logic        [31:0] wh_ff, u4_ff;

   assign w2    = {{10{wp_ff[31]}}, wp_ff[31:10]} + 32'd2097152;
   assign wh_in = $signed(w2) * h2;

   // Stage 5: round and combine with the raw term.
   logic        [31:0] w3sum, w3;
   logic signed [63:0] vv5_in;
   logic        [31:0] vv5_ff;

   assign w3sum  = wh_ff + 32'd8192;
   assign w3     = {{14{w3sum[31]}}, w3sum[31:14]};
   assign vv5_in = $signed(u4_ff) * $signed(w3);

   // Stage 6: square of the scaled value.
   logic signed [16:0] s6;
   logic signed [33:0] ss_in;
   logic        [31:0] ss_ff, vv6_ff;

   assign s6    = $signed(vv5_ff[31:15]);
   assign ss_in = s6 * s6;

   // Stage 7: scale the square by H1.
   logic signed [24:0] ssh;
   logic signed [33:0] sh_in;
   logic        [31:0] sh_ff, vv7_ff;

   assign ssh   = $signed(ss_ff[31:7]);
   assign sh_in = ssh * $signed({1'b0, h1});

   // Stage 8: subtract, clamp to 0..100 percent and drop the extra scale.
   logic [31:0] r8, clamp8;
   logic [16:0] hum_in, hum_ff;

   assign r8 = vv7_ff - {{4{sh_ff[31]}}, sh_ff[31:4]};

   always_comb begin
      priority if (r8[31]) begin
         clamp8 = '0;
      end else if (r8 > HUM_MAX) begin
         clamp8 = HUM_MAX;
      end else begin
         clamp8 = r8;
      end
   end

   assign hum_in = clamp8[28:12];

   always_ff @(posedge clock) begin
      if (adv) begin
         base_ff <= base_in;
         m5_ff   <= m5_in[31:0];
         m6_ff   <= m6_in[31:0];
         m3_ff   <= m3_in[31:0];
         u2_ff   <= u2_in;
         wa_ff   <= wa_in;
         wb_ff   <= wb_in;
         wp_ff   <= wp_in[31:0];
         u3_ff   <= u2_ff;
         wh_ff   <= wh_in[31:0];
         u4_ff   <= u3_ff;
         vv5_ff  <= vv5_in[31:0];
         ss_ff   <= ss_in[31:0];
         vv6_ff  <= vv5_ff;
         sh_ff   <= sh_in[31:0];
         vv7_ff  <= vv6_ff;
         hum_ff  <= hum_in;
      end
   end

   assign hum = hum_ff;

endmodule

### rtl/core/thpc_div.sv
// Pipelined signed division, one quotient bit per stage, truncating toward zero.
`timescale 1ns / 1ps

module thpc_div import thpc_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   input  side_type         side_in,
   output logic [DIV_W-1:0] quo,
   output side_type         side_out
);

   logic [DIV_W-1:0] rem_ff  [0:DIV_W-1];
   logic [DIV_W-1:0] numr_ff [0:DIV_W-1];
   logic [DIV_W-1:0] md_ff   [0:DIV_W-1];
   logic [DIV_W-1:0] quo_ff  [0:DIV_W];
   logic             sgn_ff  [0:DIV_W];
   side_type         side_ff [0:DIV_W];
   logic [DIV_W-1:0] q_ff;
   side_type         side_out_ff;

   // Operand stage: magnitudes and the sign of the quotient.
   always_ff @(posedge clock) begin
      if (adv) begin
         numr_ff[0] <= num[DIV_W-1] ? DIV_W'(0) - num : num;
         md_ff[0]   <= den[DIV_W-1] ? DIV_W'(0) - den : den;
         rem_ff[0]  <= '0;
         quo_ff[0]  <= '0;
         sgn_ff[0]  <= num[DIV_W-1] ^ den[DIV_W-1];
         side_ff[0] <= side_in;
      end
   end

   // Restoring steps: bring down one dividend bit, subtract where it fits.
   for (genvar k = 1; k <= DIV_W; k++) begin : g_step
      logic [DIV_W:0] trial;
      logic           ge;

      assign trial = {rem_ff[k-1], numr_ff[k-1][DIV_W-1]};
      assign ge    = trial >= {1'b0, md_ff[k-1]};

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[k]  <= {quo_ff[k-1][DIV_W-2:0], ge};
            sgn_ff[k]  <= sgn_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end

      if (k < DIV_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k]  <= ge ? DIV_W'(trial - {1'b0, md_ff[k-1]}) : trial[DIV_W-1:0];
               numr_ff[k] <= numr_ff[k-1] << 1;
               md_ff[k]   <= md_ff[k-1];
            end
         end
      end
   end

   // Sign stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff        <= sgn_ff[DIV_W] ? DIV_W'(0) - quo_ff[DIV_W] : quo_ff[DIV_W];
         side_out_ff <= side_ff[DIV_W];
      end
   end

   assign quo      = q_ff;
   assign side_out = side_out_ff;

endmodule

### rtl/core/thp_sensor_compensation.sv
// Top level of the temperature, pressure and humidity compensation pipeline.
//
//   channel   direction  transfer carries
//   req_chan  in         raw_temperature, raw_pressure, raw_humidity
//   rsp_chan  out        temperature_centi, pressure_q24_8, pressure_valid, humidity_q22_10
//   csr_chan  in         index, data (calibration register write)
//
// One item enters per cycle unless a stalled result holds the pipeline.
// The deepest part is the pressure divider, one quotient bit per stage.
// Reset clears the stage valid bits and all calibration registers to zero.
// A stalled result freezes the whole pipeline; req_chan.ready is low only then.
// Calibration writes are taken every cycle.
`timescale 1ns / 1ps

module thp_sensor_compensation import thpc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   thpc_req_if.sink   req_chan,
   thpc_rsp_if.source rsp_chan,
   thpc_csr_if.sink   csr_chan
);

   localparam int P_LAST     = 8;
   localparam int TEMP_FIRST = 4;
   localparam int SIDE_STAGE = 3 + HUM_LAT;
   localparam int LAST       = SIDE_STAGE + DIV_LAT + 5;

   // Calibration registers.
   temp_coef_type      temp_calib_ff;
   press_low_type      press_low_ff;
   press_high_type     press_high_ff;
   logic signed [15:0] press_last_ff;
   hum_coef_type       hum_calib_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_last_ff <= '0;
         hum_calib_ff  <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_TEMP_CALIB: temp_calib_ff <= csr_chan.data[47:0];
            CSR_PRESS_LOW:  press_low_ff  <= csr_chan.data;
            CSR_PRESS_HIGH: press_high_ff <= csr_chan.data;
            CSR_PRESS_LAST: press_last_ff <= csr_chan.data[15:0];
            CSR_HUM_CALIB:  hum_calib_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   logic        [15:0] t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = temp_calib_ff.t1;
   assign t2 = temp_calib_ff.t2;
   assign t3 = temp_calib_ff.t3;
   assign p1 = press_low_ff.p1;
   assign p2 = press_low_ff.p2;
   assign p3 = press_low_ff.p3;
   assign p4 = press_low_ff.p4;
   assign p5 = press_high_ff.p5;
   assign p6 = press_high_ff.p6;
   assign p7 = press_high_ff.p7;
   assign p8 = press_high_ff.p8;
   assign p9 = press_last_ff;

   // Pipeline advance and valid bits.
   logic            adv;
   logic [LAST:1]   vld_ff;

   assign adv            = !vld_ff[LAST] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:1], req_chan.valid};
      end
   end

   // Raw readings carried to where they are used.
   logic [19:0] adc_p_line_ff [1:P_LAST];
   logic [15:0] adc_h_line_ff [1:3];

   always_ff @(posedge clock) begin
      if (adv) begin
         adc_p_line_ff[1] <= req_chan.raw_pressure;
         for (int k = 2; k <= P_LAST; k++) adc_p_line_ff[k] <= adc_p_line_ff[k-1];
         adc_h_line_ff[1] <= req_chan.raw_humidity;
         for (int k = 2; k <= 3; k++) adc_h_line_ff[k] <= adc_h_line_ff[k-1];
      end
   end

   // Stage 1: temperature differences and their products.
   logic signed [17:0] a_in;
   logic signed [16:0] b_in;
   logic signed [33:0] s1_at2_in, s1_bb_in, s1_at2_ff, s1_bb_ff;

   assign a_in      = $signed({1'b0, req_chan.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
   assign b_in      = $signed({1'b0, req_chan.raw_temperature[19:4]}) - $signed({1'b0, t1});
   assign s1_at2_in = a_in * t2;
   assign s1_bb_in  = b_in * b_in;

   // Stage 2: first term and the T3 product.
   logic        [31:0] s2_v1_in, s2_v1_ff;
   logic signed [19:0] bb_sh;
   logic signed [35:0] s2_bt3_in, s2_bt3_ff;

   assign s2_v1_in  = {{11{s1_at2_ff[31]}}, s1_at2_ff[31:11]};
   assign bb_sh     = $signed(s1_bb_ff[31:12]);
   assign s2_bt3_in = bb_sh * t3;

   // Stage 3: fine temperature.
   logic [31:0] s3_fine_in, s3_fine_ff;

   assign s3_fine_in = s2_v1_ff + {{14{s2_bt3_ff[31]}}, s2_bt3_ff[31:14]};

   // Stage 4: temperature result and the pressure offset.
   logic        [31:0] t5, temp_in;
   logic signed [32:0] s4_x1_in, s4_x1_ff;
   logic signed [31:0] temp_line_ff [TEMP_FIRST:SIDE_STAGE];

   assign t5       = {s3_fine_ff[29:0], 2'b00} + s3_fine_ff + 32'd128;
   assign temp_in  = {{8{t5[31]}}, t5[31:8]};
   assign s4_x1_in = $signed({s3_fine_ff[31], s3_fine_ff}) - 33'sd128000;

   // Stage 5: square and linear products of the offset.
   logic signed [65:0] x1sq_in;
   logic signed [48:0] s5_x1p5_in, s5_x1p2_in;
   logic        [63:0] s5_x1sq_ff;
   logic signed [48:0] s5_x1p5_ff, s5_x1p2_ff;

   assign x1sq_in    = s4_x1_ff * s4_x1_ff;
   assign s5_x1p5_in = s4_x1_ff * p5;
   assign s5_x1p2_in = s4_x1_ff * p2;

   // Stage 6: partial products of the square by P6 and P3.
   logic signed [48:0] s6_lo6_in, s6_lo3_in, s6_lo6_ff, s6_lo3_ff;
   logic signed [47:0] hi6_full, hi3_full;
   logic        [31:0] s6_hi6_ff, s6_hi3_ff;
   logic signed [48:0] s6_x1p5_ff, s6_x1p2_ff;

   assign s6_lo6_in = $signed({1'b0, s5_x1sq_ff[31:0]}) * p6;
   assign s6_lo3_in = $signed({1'b0, s5_x1sq_ff[31:0]}) * p3;
   assign hi6_full  = $signed(s5_x1sq_ff[63:32]) * p6;
   assign hi3_full  = $signed(s5_x1sq_ff[63:32]) * p3;

   // Stage 7: sum the partial products.
   logic        [63:0] s7_q6_in, s7_q3_in, s7_q6_ff, s7_q3_ff;
   logic signed [48:0] s7_x1p5_ff, s7_x1p2_ff;

   assign s7_q6_in = {{15{s6_lo6_ff[48]}}, s6_lo6_ff} + {s6_hi6_ff, 32'h0};
   assign s7_q3_in = {{15{s6_lo3_ff[48]}}, s6_lo3_ff} + {s6_hi3_ff, 32'h0};

   // Stage 8: the two pressure sums.
   logic [63:0] s8_x2_in, s8_x1b_in, s8_x2_ff, s8_x1b_ff;

   assign s8_x2_in  = s7_q6_ff + ({{15{s7_x1p5_ff[48]}}, s7_x1p5_ff} << 17)
                    + ({{48{p4[15]}}, p4} << 35);
   assign s8_x1b_in = {{8{s7_q3_ff[63]}}, s7_q3_ff[63:8]}
                    + ({{15{s7_x1p2_ff[48]}}, s7_x1p2_ff} << 12);

   // Stage 9: divisor offset and dividend.
   logic [20:0] pp;
   logic [63:0] s9_y_in, s9_num_in, s9_y_ff, s9_num_ff;

   assign pp        = 21'h100000 - {1'b0, adc_p_line_ff[P_LAST]};
   assign s9_y_in   = s8_x1b_ff + 64'h0000_8000_0000_0000;
   assign s9_num_in = {12'b0, pp, 31'b0} - s8_x2_ff;

   // Stage 10: P1 partial products and the dividend scale.
   logic [47:0] s10_ylo_in, yhi_full, s10_ylo_ff;
   logic [31:0] s10_yhi_ff;
   logic [63:0] s10_n_in, s10_n_ff;

   assign s10_ylo_in = s9_y_ff[31:0] * p1;
   assign yhi_full   = s9_y_ff[63:32] * p1;
   assign s10_n_in   = s9_num_ff * 64'd3125;

   // Stage 11: divisor and the zero check.
   logic [63:0] yp, s11_d_in, s11_d_ff, s11_n_ff;
   logic        s11_pvalid_in, s11_pvalid_ff;
   logic [16:0] hum_s11;
   side_type    side_s11;

   assign yp            = {16'b0, s10_ylo_ff} + {s10_yhi_ff, 32'h0};
   assign s11_d_in      = {{33{yp[63]}}, yp[63:33]};
   assign s11_pvalid_in = |yp[63:33];

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_at2_ff  <= s1_at2_in;
         s1_bb_ff   <= s1_bb_in;
         s2_v1_ff   <= s2_v1_in;
         s2_bt3_ff  <= s2_bt3_in;
         s3_fine_ff <= s3_fine_in;
         temp_line_ff[TEMP_FIRST] <= $signed(temp_in);
         for (int k = TEMP_FIRST + 1; k <= SIDE_STAGE; k++) temp_line_ff[k] <= temp_line_ff[k-1];
         s4_x1_ff   <= s4_x1_in;
         s5_x1sq_ff <= x1sq_in[63:0];
         s5_x1p5_ff <= s5_x1p5_in;
         s5_x1p2_ff <= s5_x1p2_in;
         s6_lo6_ff  <= s6_lo6_in;
         s6_lo3_ff  <= s6_lo3_in;
         s6_hi6_ff  <= hi6_full[31:0];
         s6_hi3_ff  <= hi3_full[31:0];
         s6_x1p5_ff <= s5_x1p5_ff;
         s6_x1p2_ff <= s5_x1p2_ff;
         s7_q6_ff   <= s7_q6_in;
         s7_q3_ff   <= s7_q3_in;
         s7_x1p5_ff <= s6_x1p5_ff;
         s7_x1p2_ff <= s6_x1p2_ff;
         s8_x2_ff   <= s8_x2_in;
         s8_x1b_ff  <= s8_x1b_in;
         s9_y_ff    <= s9_y_in;
         s9_num_ff  <= s9_num_in;
         s10_ylo_ff <= s10_ylo_in;
         s10_yhi_ff <= yhi_full[31:0];
         s10_n_ff   <= s10_n_in;
         s11_d_ff   <= s11_d_in;
         s11_n_ff   <= s10_n_ff;
         s11_pvalid_ff <= s11_pvalid_in;
      end
   end

   // Humidity runs beside the pressure path and lands in the same stage.
   thpc_hum u_hum (
      .clock (clock),
      .adv   (adv),
      .fine  ($signed(s3_fine_ff)),
      .adc_h (adc_h_line_ff[3]),
      .coef  (hum_calib_ff),
      .hum   (hum_s11)
   );

   assign side_s11.temp   = temp_line_ff[SIDE_STAGE];
   assign side_s11.hum    = hum_s11;
   assign side_s11.pvalid = s11_pvalid_ff;

   logic [DIV_W-1:0] div_q;
   side_type         div_side;

   thpc_div u_div (
      .clock    (clock),
      .adv      (adv),
      .num      (s11_n_ff),
      .den      (s11_d_ff),
      .side_in  (side_s11),
      .quo      (div_q),
      .side_out (div_side)
   );

   // Post-division stage 1: square of the scaled quotient and the P8 products.
   logic [63:0]        q13;
   logic [63:0]        d1_llq_in, lhq_full, d1_llq_ff, d1_p_ff;
   logic [31:0]        d1_lhq_ff, d1_hi8_ff;
   logic signed [48:0] d1_lo8_in, d1_lo8_ff;
   logic signed [47:0] hi8_full;
   side_type           d1_side_ff;

   assign q13       = {{13{div_q[63]}}, div_q[63:13]};
   assign d1_llq_in = q13[31:0] * q13[31:0];
   assign lhq_full  = q13[31:0] * q13[63:32];
   assign d1_lo8_in = $signed({1'b0, div_q[31:0]}) * p8;
   assign hi8_full  = $signed(div_q[63:32]) * p8;

   // Post-division stage 2: assemble the square and the P8 term.
   logic [63:0] d2_qq_in, y2f, d2_y2_in, d2_qq_ff, d2_y2_ff, d2_p_ff;
   side_type    d2_side_ff;

   assign d2_qq_in = d1_llq_ff + {d1_lhq_ff[30:0], 1'b0, 32'h0};
   assign y2f      = {{15{d1_lo8_ff[48]}}, d1_lo8_ff} + {d1_hi8_ff, 32'h0};
   assign d2_y2_in = {{19{y2f[63]}}, y2f[63:19]};

   // Post-division stage 3: P9 partial products.
   logic signed [48:0] d3_lo9_in, d3_lo9_ff;
   logic signed [47:0] hi9_full;
   logic        [31:0] d3_hi9_ff;
   logic        [63:0] d3_y2_ff, d3_p_ff;
   side_type           d3_side_ff;

   assign d3_lo9_in = $signed({1'b0, d2_qq_ff[31:0]}) * p9;
   assign hi9_full  = $signed(d2_qq_ff[63:32]) * p9;

   // Post-division stage 4: P9 term.
   logic [63:0] y1f, d4_y1_in, d4_y1_ff, d4_y2_ff, d4_p_ff;
   side_type    d4_side_ff;

   assign y1f      = {{15{d3_lo9_ff[48]}}, d3_lo9_ff} + {d3_hi9_ff, 32'h0};
   assign d4_y1_in = {{25{y1f[63]}}, y1f[63:25]};

   // Output stage: final pressure, forced to zero when the divisor was zero.
   logic [63:0]        psum, pr;
   logic [31:0]        out_pres_in, out_pres_ff;
   logic signed [31:0] out_temp_ff;
   logic               out_pvalid_ff;
   logic [16:0]        out_hum_ff;

   assign psum        = d4_p_ff + d4_y1_ff + d4_y2_ff;
   assign pr          = {{8{psum[63]}}, psum[63:8]} + ({{48{p7[15]}}, p7} << 4);
   assign out_pres_in = d4_side_ff.pvalid ? pr[31:0] : 32'h0;

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_llq_ff     <= d1_llq_in;
         d1_lhq_ff     <= lhq_full[31:0];
         d1_lo8_ff     <= d1_lo8_in;
         d1_hi8_ff     <= hi8_full[31:0];
         d1_p_ff       <= div_q;
         d1_side_ff    <= div_side;
         d2_qq_ff      <= d2_qq_in;
         d2_y2_ff      <= d2_y2_in;
         d2_p_ff       <= d1_p_ff;
         d2_side_ff    <= d1_side_ff;
         d3_lo9_ff     <= d3_lo9_in;
         d3_hi9_ff     <= hi9_full[31:0];
         d3_y2_ff      <= d2_y2_ff;
         d3_p_ff       <= d2_p_ff;
         d3_side_ff    <= d2_side_ff;
         d4_y1_ff      <= d4_y1_in;
         d4_y2_ff      <= d3_y2_ff;
         d4_p_ff       <= d3_p_ff;
         d4_side_ff    <= d3_side_ff;
         out_pres_ff   <= out_pres_in;
         out_temp_ff   <= d4_side_ff.temp;
         out_pvalid_ff <= d4_side_ff.pvalid;
         out_hum_ff    <= d4_side_ff.hum;
      end
   end

   assign rsp_chan.valid             = vld_ff[LAST];
   assign rsp_chan.temperature_centi = out_temp_ff;
   assign rsp_chan.pressure_q24_8    = out_pres_ff;
   assign rsp_chan.pressure_valid    = out_pvalid_ff;
   assign rsp_chan.humidity_q22_10   = out_hum_ff;

   // An accepted request occupies the first stage on the next cycle.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[1])
      else $error("accepted request did not enter the pipeline");

   // A frozen pipeline keeps every valid bit in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid bits moved during a stall");

   // A flagged pressure result is zero.
   a_pres_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.pressure_valid |-> rsp_chan.pressure_q24_8 == 32'h0)
      else $error("pressure not zero with zero divisor");

   // Humidity stays within its clamp.
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.humidity_q22_10 <= 17'd102400)
      else $error("humidity above full scale");

endmodule
